>>> rtl/blr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  // tile geometry
  localparam int TILE_SIDE = 64;
  localparam int COORD_W   = 6;
  localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIDE - 1);

  // color and error term widths
  localparam int COLOR_W = 8;
  localparam int ERR_W   = 10;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [COLOR_W-1:0]      color_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // one classified line, ready for the pixel walker
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t count;    // pixels minus one along the major axis
    logic   x_major;  // x steps every pixel
    logic   y_down;   // y moves toward smaller values
    err_t   f0;       // initial decision term
    err_t   inc_le;   // added when the term is not positive
    err_t   inc_gt;   // added when the minor axis steps
    color_t red;
    color_t green;
    color_t blue;
  } cmd_t;

  // saturate a coordinate to the tile
  function automatic coord_t clamp_coord(input coord_t v);
    clamp_coord = (v > TILE_MAX) ? TILE_MAX : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/blr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module blr_front (
  input  wire logic            line_valid,
  output logic                 line_stall,
  input  wire blr_pkg::coord_t start_x,
  input  wire blr_pkg::coord_t start_y,
  input  wire blr_pkg::coord_t end_x,
  input  wire blr_pkg::coord_t end_y,
  input  wire blr_pkg::color_t red,
  input  wire blr_pkg::color_t green,
  input  wire blr_pkg::color_t blue,
  input  wire logic            q_full,
  output logic                 push,
  output blr_pkg::cmd_t        cmd
);
  import blr_pkg::*;

  coord_t cx1, cy1, cx2, cy2;
  coord_t xa, ya, xb, yb;
  coord_t dx, ady;
  logic   swap, dy_neg, vertical, x_major;
  err_t   dx_e, ady_e;

  // request handshake: accept whenever the queue has room
  assign line_stall = q_full;
  assign push       = line_valid && !q_full;

  // clamp and order endpoints so that x never decreases
  always_comb begin
    cx1  = clamp_coord(start_x);
    cy1  = clamp_coord(start_y);
    cx2  = clamp_coord(end_x);
    cy2  = clamp_coord(end_y);
    swap = cx1 > cx2;
    xa   = swap ? cx2 : cx1;
    ya   = swap ? cy2 : cy1;
    xb   = swap ? cx1 : cx2;
    yb   = swap ? cy1 : cy2;
  end

  // deltas and octant
  always_comb begin
    dx       = xb - xa;
    dy_neg   = yb < ya;
    ady      = dy_neg ? (ya - yb) : (yb - ya);
    vertical = (dx == '0);
    x_major  = (dx >= ady);
    dx_e     = ERR_W'(dx);
    ady_e    = ERR_W'(ady);
  end

  // build the walker command
  always_comb begin
    cmd.x0    = xa;
    cmd.red   = red;
    cmd.green = green;
    cmd.blue  = blue;
    cmd.x_major = x_major;
    if (x_major) begin
      cmd.y0     = ya;
      cmd.y_down = dy_neg;
      cmd.count  = dx;
      cmd.f0     = (ady_e <<< 1) - dx_e;
      cmd.inc_le = ady_e <<< 1;
      cmd.inc_gt = (ady_e <<< 1) - (dx_e <<< 1);
    end else begin
      // a vertical line is always drawn with y increasing
      if (vertical && dy_neg) begin
        cmd.y0     = yb;
        cmd.y_down = 1'b0;
      end else begin
        cmd.y0     = ya;
        cmd.y_down = dy_neg;
      end
      cmd.count  = ady;
      cmd.f0     = (dx_e <<< 1) - ady_e;
      cmd.inc_le = dx_e <<< 1;
      cmd.inc_gt = (dx_e <<< 1) - (ady_e <<< 1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/blr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module blr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire blr_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output blr_pkg::cmd_t      head
);
  import blr_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/blr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module blr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire blr_pkg::cmd_t q_head,
  output logic               pop,
  output logic               pixel_valid,
  input  wire logic          pixel_stall,
  output blr_pkg::coord_t    pixel_x,
  output blr_pkg::coord_t    pixel_y,
  output blr_pkg::color_t    pixel_red,
  output blr_pkg::color_t    pixel_green,
  output blr_pkg::color_t    pixel_blue,
  output logic               last_pixel
);
  import blr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  cmd_t   cur;
  coord_t cur_x, cur_y, remain;
  err_t   f;
  logic   slot_free, emit, step_minor, done;
  coord_t cur_x_next, cur_y_next;
  err_t   f_next;

  assign slot_free  = !pixel_valid || !pixel_stall;
  assign pop        = (state == ST_IDLE) && q_valid;
  assign emit       = (state == ST_RUN) && slot_free;
  assign done       = (remain == '0);
  assign step_minor = (f > 0);

  // next position and decision term
  always_comb begin
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (cur.x_major) begin
      cur_x_next = cur_x + 1'b1;
      if (step_minor) begin
        cur_y_next = cur.y_down ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end else begin
      cur_y_next = cur.y_down ? cur_y - 1'b1 : cur_y + 1'b1;
      if (step_minor) begin
        cur_x_next = cur_x + 1'b1;
      end
    end
    f_next = f + (step_minor ? cur.inc_gt : cur.inc_le);
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit && done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walker registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= q_head;
      cur_x  <= q_head.x0;
      cur_y  <= q_head.y0;
      remain <= q_head.count;
      f      <= q_head.f0;
    end else if (emit) begin
      cur_x  <= cur_x_next;
      cur_y  <= cur_y_next;
      remain <= remain - 1'b1;
      f      <= f_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (slot_free) begin
      pixel_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      pixel_red   <= cur.red;
      pixel_green <= cur.green;
      pixel_blue  <= cur.blue;
      last_pixel  <= done;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bresenham_line_rasterizer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                 | payload
// line     | line_valid / line_stall   | start_x start_y end_x end_y red green blue
// pixel    | pixel_valid / pixel_stall | pixel_x pixel_y pixel_red/green/blue last_pixel
//
// the pixel walker loads a line's command from the queue, then sends one pixel per
// cycle while the output is not stalled.
// the front classifies a line in the cycle it is accepted and holds up to two
// lines in its queue while the walker draws.
// rst is synchronous and active high; it empties the queue and the output.
// pixel_stall freezes the walker; line_stall is high only while the queue is full.

module bresenham_line_rasterizer_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            line_valid,
  output logic                 line_stall,
  input  wire blr_pkg::coord_t start_x,
  input  wire blr_pkg::coord_t start_y,
  input  wire blr_pkg::coord_t end_x,
  input  wire blr_pkg::coord_t end_y,
  input  wire blr_pkg::color_t red,
  input  wire blr_pkg::color_t green,
  input  wire blr_pkg::color_t blue,
  output logic                 pixel_valid,
  input  wire logic            pixel_stall,
  output blr_pkg::coord_t      pixel_x,
  output blr_pkg::coord_t      pixel_y,
  output blr_pkg::color_t      pixel_red,
  output blr_pkg::color_t      pixel_green,
  output blr_pkg::color_t      pixel_blue,
  output logic                 last_pixel
);
  import blr_pkg::*;

  logic push, q_full, q_pop, q_valid;
  cmd_t push_cmd, q_head;

  // classify incoming lines
  blr_front u_front (
    .line_valid (line_valid),
    .line_stall (line_stall),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // command queue
  blr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // pixel walker
  blr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (q_pop),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .last_pixel  (last_pixel)
  );

  // walker only loads from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");

  // a taken pixel that is not the last is followed at once by the next one
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall && !last_pixel) |=> pixel_valid)
    else $error("gap inside a line");

  // consecutive pixels of one line are neighbors along the major axis
  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall && !last_pixel) |=>
      (pixel_x == COORD_W'($past(pixel_x) + 1'b1) ||
       pixel_y == COORD_W'($past(pixel_y) + 1'b1) ||
       pixel_y == COORD_W'($past(pixel_y) - 1'b1)))
    else $error("pixel step is not a unit move");

endmodule

`default_nettype wire
